### sv/mvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants
// Word, product and accumulator types of the 4x4 matrix-vector datapath.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int unsigned DIM       = 4;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned PAIR_W    = PROD_W + 1;
    localparam int unsigned SUM_W     = PROD_W + 2;
    localparam int unsigned ROW_W     = 2;
    localparam int unsigned FRAC_BITS = 16;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [PAIR_W-1:0] t_pair;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic        [ROW_W-1:0]  t_row;

    localparam t_word SAT_MAX = 32'sh7FFF_FFFF;
    localparam t_word SAT_MIN = 32'sh8000_0000;

endpackage

### sv/mvt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_in_if / mvt_out_if: stream channels
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mvt_in_if;
    logic                valid;
    logic                ready;
    logic                mode;
    mvt_pkg::t_row       row_index;
    mvt_pkg::t_word      elem_0;
    mvt_pkg::t_word      elem_1;
    mvt_pkg::t_word      elem_2;
    mvt_pkg::t_word      elem_3;

    modport source (output valid, mode, row_index, elem_0, elem_1, elem_2, elem_3,
                    input ready);
    modport sink   (input valid, mode, row_index, elem_0, elem_1, elem_2, elem_3,
                    output ready);
endinterface

interface mvt_out_if;
    logic                valid;
    logic                ready;
    mvt_pkg::t_word      out_0;
    mvt_pkg::t_word      out_1;
    mvt_pkg::t_word      out_2;
    mvt_pkg::t_word      out_3;

    modport source (output valid, out_0, out_1, out_2, out_3, input ready);
    modport sink   (input valid, out_0, out_1, out_2, out_3, output ready);
endinterface

### sv/mvt_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_mul: matrix store and product stage
// Holds the 4x4 matrix, writes rows on load items and registers the sixteen
// element products of a transform item.
// ----------------------------------------------------------------------------
module mvt_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_en,
    input  logic                i_mode,
    input  mvt_pkg::t_row       i_row,
    input  mvt_pkg::t_word      i_elem [mvt_pkg::DIM],
    output logic                o_valid,
    output mvt_pkg::t_prod      o_prod [mvt_pkg::DIM][mvt_pkg::DIM]
);

    mvt_pkg::t_word r_mat  [mvt_pkg::DIM][mvt_pkg::DIM];
    mvt_pkg::t_prod r_prod [mvt_pkg::DIM][mvt_pkg::DIM];
    logic           r_valid;
    logic           w_accept;

    assign w_accept = i_valid && i_en;

    // The store is written at the same edge that a load transfer completes, so
    // a transform accepted later always multiplies with the updated row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                for (int c = 0; c < mvt_pkg::DIM; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (w_accept && i_mode == mvt_pkg::MODE_LOAD) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
                r_mat[i_row][c] <= i_elem[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && i_mode == mvt_pkg::MODE_XFORM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                for (int c = 0; c < mvt_pkg::DIM; c++) begin
                    r_prod[r][c] <= mvt_pkg::t_prod'(r_mat[r][c])
                                  * mvt_pkg::t_prod'(i_elem[c]);
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

### sv/mvt_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_sum: two-level adder tree
// Adds the four products of each row in two registered levels, at full width.
// ----------------------------------------------------------------------------
module mvt_sum (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_en_pair,
    input  logic                i_en_sum,
    input  mvt_pkg::t_prod      i_prod [mvt_pkg::DIM][mvt_pkg::DIM],
    output logic                o_valid_pair,
    output logic                o_valid,
    output mvt_pkg::t_sum       o_sum [mvt_pkg::DIM]
);

    mvt_pkg::t_pair r_pair [mvt_pkg::DIM][2];
    mvt_pkg::t_sum  r_sum  [mvt_pkg::DIM];
    logic           r_valid_pair;
    logic           r_valid_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_pair <= 1'b0;
            r_valid_sum  <= 1'b0;
        end else begin
            if (i_en_pair) begin
                r_valid_pair <= i_valid;
            end
            if (i_en_sum) begin
                r_valid_sum <= r_valid_pair;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en_pair) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                r_pair[r][0] <= mvt_pkg::t_pair'(i_prod[r][0])
                              + mvt_pkg::t_pair'(i_prod[r][1]);
                r_pair[r][1] <= mvt_pkg::t_pair'(i_prod[r][2])
                              + mvt_pkg::t_pair'(i_prod[r][3]);
            end
        end
        if (i_en_sum) begin
            for (int r = 0; r < mvt_pkg::DIM; r++) begin
                r_sum[r] <= mvt_pkg::t_sum'(r_pair[r][0]) + mvt_pkg::t_sum'(r_pair[r][1]);
            end
        end
    end

    assign o_valid_pair = r_valid_pair;
    assign o_valid      = r_valid_sum;
    assign o_sum        = r_sum;

endmodule

### sv/mvt_sat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvt_sat: scaling and saturation stage
// Drops the fraction bits of each row sum (rounding toward minus infinity)
// and clamps the result to the signed 32-bit range into the output register.
// ----------------------------------------------------------------------------
module mvt_sat #(
    parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_en,
    input  mvt_pkg::t_sum       i_sum [mvt_pkg::DIM],
    output logic                o_valid,
    output mvt_pkg::t_word      o_out [mvt_pkg::DIM]
);

    localparam int unsigned TOP_W = mvt_pkg::SUM_W - mvt_pkg::WORD_W + 1;

    mvt_pkg::t_sum  w_shift [mvt_pkg::DIM];
    mvt_pkg::t_word n_out   [mvt_pkg::DIM];
    mvt_pkg::t_word r_out   [mvt_pkg::DIM];
    logic           r_valid;

    always_comb begin
        for (int r = 0; r < mvt_pkg::DIM; r++) begin
            w_shift[r] = i_sum[r] >>> FRAC_BITS;
            // The value fits when every bit from the word's sign bit upward agrees.
            if (w_shift[r][mvt_pkg::SUM_W-1 -: TOP_W] == '0 ||
                w_shift[r][mvt_pkg::SUM_W-1 -: TOP_W] == '1) begin
                n_out[r] = w_shift[r][mvt_pkg::WORD_W-1:0];
            end else if (w_shift[r][mvt_pkg::SUM_W-1]) begin
                n_out[r] = mvt_pkg::SAT_MIN;
            end else begin
                n_out[r] = mvt_pkg::SAT_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_out   = r_out;

endmodule

### sv/matrix_vector_transform_4x4.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4: 4x4 fixed-point matrix-vector multiplier
// Load items write one matrix row; transform items give the four saturated
// Q16.16 dot products of the matrix rows with the input vector.
// ----------------------------------------------------------------------------
//  Channel   Dir   Payload                               Transfer
//  i_in      in    mode, row_index, elem_0 .. elem_3     valid && ready
//  o_out     out   out_0 .. out_3                        valid && ready
//
//  One item enters per cycle unless the pipeline is full and the output stalls.
//  A transform result passes the product, pair-sum, row-sum and saturation registers.
//  A load item updates the matrix at its transfer and yields no result.
//  Reset clears the matrix to zero and empties the pipeline.
//  Each stage advances when it is empty or the next stage advances, so
//  bubbles close up during an output stall and nothing is lost or repeated.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 #(
    parameter int unsigned FRAC_BITS = mvt_pkg::FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mvt_in_if.sink      i_in,
    mvt_out_if.source   o_out
);

    logic           w_en_mul;
    logic           w_en_pair;
    logic           w_en_sum;
    logic           w_en_sat;
    logic           w_v_mul;
    logic           w_v_pair;
    logic           w_v_sum;
    logic           w_v_sat;
    mvt_pkg::t_word w_elem [mvt_pkg::DIM];
    mvt_pkg::t_prod w_prod [mvt_pkg::DIM][mvt_pkg::DIM];
    mvt_pkg::t_sum  w_sum  [mvt_pkg::DIM];
    mvt_pkg::t_word w_out  [mvt_pkg::DIM];

    assign w_en_sat  = !w_v_sat  || o_out.ready;
    assign w_en_sum  = !w_v_sum  || w_en_sat;
    assign w_en_pair = !w_v_pair || w_en_sum;
    assign w_en_mul  = !w_v_mul  || w_en_pair;

    assign i_in.ready = w_en_mul;

    assign w_elem[0] = i_in.elem_0;
    assign w_elem[1] = i_in.elem_1;
    assign w_elem[2] = i_in.elem_2;
    assign w_elem[3] = i_in.elem_3;

    mvt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_en    (w_en_mul),
        .i_mode  (i_in.mode),
        .i_row   (i_in.row_index),
        .i_elem  (w_elem),
        .o_valid (w_v_mul),
        .o_prod  (w_prod)
    );

    mvt_sum u_sum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v_mul),
        .i_en_pair    (w_en_pair),
        .i_en_sum     (w_en_sum),
        .i_prod       (w_prod),
        .o_valid_pair (w_v_pair),
        .o_valid      (w_v_sum),
        .o_sum        (w_sum)
    );

    mvt_sat #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v_sum),
        .i_en    (w_en_sat),
        .i_sum   (w_sum),
        .o_valid (w_v_sat),
        .o_out   (w_out)
    );

    assign o_out.valid = w_v_sat;
    assign o_out.out_0 = w_out[0];
    assign o_out.out_1 = w_out[1];
    assign o_out.out_2 = w_out[2];
    assign o_out.out_3 = w_out[3];

    // A transform transfer always lands in the product stage.
    a_xform_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == mvt_pkg::MODE_XFORM) |=> w_v_mul)
        else $error("transform transfer did not enter the product stage");

    // A load transfer never creates a pipeline entry.
    a_load_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.mode == mvt_pkg::MODE_LOAD) |=> !w_v_mul)
        else $error("load transfer created a pipeline entry");

    // A row sum behind a stalled full output register stays in place.
    a_sum_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_v_sum && w_v_sat && !o_out.ready) |=> (w_v_sum && $stable(w_sum[0])))
        else $error("row sum lost during an output stall");

    // The input side is blocked only when every stage holds an item.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (w_v_mul && w_v_pair && w_v_sum && w_v_sat))
        else $error("input stalled with a bubble in the pipeline");

endmodule
